// ===== rtl/sdspi_pkg.sv =====
`default_nettype none
package sdspi_pkg;

	// Sizes
	localparam int MAX_BLOCK_BYTES = 512;
	localparam int DUMMY_BYTES     = 10;
	localparam int CNT_W           = 10;

	localparam logic [CNT_W-1:0] MAX_LEN   = CNT_W'(MAX_BLOCK_BYTES);
	localparam logic [CNT_W-1:0] DUMMY_CNT = CNT_W'(DUMMY_BYTES);

	// Reset values of the configuration registers
	localparam logic [9:0] BLOCK_LEN_RST  = 10'd512;
	localparam logic [7:0] POLL_LIMIT_RST = 8'd8;

	// Configuration register indexes
	localparam logic REG_BLOCK_LEN  = 1'b0;
	localparam logic REG_POLL_LIMIT = 1'b1;

	// Card commands
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_SEND_OP   = 6'd1;
	localparam logic [5:0] CMD_RD_SINGLE = 6'd17;
	localparam logic [5:0] CMD_WR_SINGLE = 6'd24;

	// Bytes on the wire
	localparam logic [7:0] CMD_START  = 8'h40;
	localparam logic [7:0] CMD_CRC    = 8'h95;
	localparam logic [7:0] DATA_TOKEN = 8'hFE;
	localparam logic [7:0] IDLE_BYTE  = 8'hFF;
	localparam logic [7:0] BUSY_BYTE  = 8'h00;
	localparam logic [4:0] RESP_MASK  = 5'h1F;
	localparam logic [4:0] RESP_OK    = 5'h05;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_BYTE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CMD_REJ  = 2'd1,
		ST_DATA_REJ = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_DUMMY    = 4'd1,
		PH_FRAME    = 4'd2,
		PH_POLL     = 4'd3,
		PH_TOKEN    = 4'd4,
		PH_RD_DATA  = 4'd5,
		PH_RD_CRC   = 4'd6,
		PH_WR_TOKEN = 4'd7,
		PH_WR_DATA  = 4'd8,
		PH_WR_CRC   = 4'd9,
		PH_WR_RESP  = 4'd10,
		PH_WR_BUSY  = 4'd11
	} phase_t;

	// One result item
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       cs_active;
		logic       rd_valid;
		logic [7:0] rd_byte;
		logic       done_res;
		status_t    status;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/sd_spi_block_host_unit.sv =====
// SD card SPI-mode host sequencer.
// A result item passes through the input register, then the result register;
// one item per cycle sustained while m_axis_tready stays high.
// The sequencer state is updated in the single step between the two registers.
// Reset (arst_n low, asynchronous): idle, no items held, block_len 512, poll_limit 8.
`default_nettype none
module sd_spi_block_host_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // lba[31:0], rx_byte[39:32], wr_byte[47:40]
	input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
	// result items
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // tx_byte[7:0], cs_active[8], rd_byte[16:9],
	                                        // done_res[17], status[19:18], zero[23:20]
	output logic [1:0]       m_axis_tuser,  // tx_valid[0], rd_valid[1]
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [9:0]  cfg_data
);

	// Input register
	logic                  vld_s1;
	sdspi_pkg::req_t       req_s1;
	logic [31:0]           addr_s1;
	logic [7:0]            rx_s1;
	logic [7:0]            wb_s1;

	// Result register
	logic                  out_vld_q;
	sdspi_pkg::res_t       res_q;

	// Sequencer state and configuration
	sdspi_pkg::phase_t     ph_q, ph_d;
	logic [sdspi_pkg::CNT_W-1:0] bc_q, bc_d;
	logic [7:0]            pc_q, pc_d;
	logic [5:0]            cmd_q, cmd_d;
	logic [31:0]           arg_q, arg_d;
	logic [9:0]            block_len_q;
	logic [7:0]            poll_limit_q;

	logic                  advance;
	sdspi_pkg::res_t       res_d;

	assign advance       = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= sdspi_pkg::req_t'(s_axis_tuser);
			addr_s1 <= s_axis_tdata[31:0];
			rx_s1   <= s_axis_tdata[39:32];
			wb_s1   <= s_axis_tdata[47:40];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_len_q  <= sdspi_pkg::BLOCK_LEN_RST;
			poll_limit_q <= sdspi_pkg::POLL_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_idx == sdspi_pkg::REG_BLOCK_LEN)
				block_len_q <= cfg_data;
			if (cfg_idx == sdspi_pkg::REG_POLL_LIMIT)
				poll_limit_q <= cfg_data[7:0];
		end
	end

	// Sequencer step: next state and result for the held item
	always_comb begin
		logic [sdspi_pkg::CNT_W-1:0] len;
		logic [7:0]  lim;
		logic        do_start;
		logic [5:0]  st_idx;
		logic [31:0] st_arg;
		logic        do_fin;
		sdspi_pkg::status_t fin_st;
		logic [7:0]  arg_byte;

		len      = (block_len_q > sdspi_pkg::MAX_LEN) ? sdspi_pkg::MAX_LEN : block_len_q;
		lim      = (poll_limit_q == 8'd0) ? 8'd1 : poll_limit_q;
		do_start = 1'b0;
		st_idx   = '0;
		st_arg   = '0;
		do_fin   = 1'b0;
		fin_st   = sdspi_pkg::ST_OK;

		// argument byte, most significant first
		case (bc_q[2:0])
			3'd1:    arg_byte = arg_q[31:24];
			3'd2:    arg_byte = arg_q[23:16];
			3'd3:    arg_byte = arg_q[15:8];
			default: arg_byte = arg_q[7:0];
		endcase

		ph_d  = ph_q;
		bc_d  = bc_q;
		pc_d  = pc_q;
		cmd_d = cmd_q;
		arg_d = arg_q;
		res_d = '0;

		case (req_s1)
			sdspi_pkg::REQ_INIT: begin
				ph_d            = sdspi_pkg::PH_DUMMY;
				bc_d            = sdspi_pkg::CNT_W'(1);
				pc_d            = '0;
				res_d.tx_valid  = 1'b1;
				res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
			end
			sdspi_pkg::REQ_READ, sdspi_pkg::REQ_WRITE: begin
				pc_d     = '0;
				do_start = 1'b1;
				st_idx   = (req_s1 == sdspi_pkg::REQ_READ) ? sdspi_pkg::CMD_RD_SINGLE
				                                           : sdspi_pkg::CMD_WR_SINGLE;
				st_arg   = addr_s1;
			end
			default: begin
				case (ph_q)
					sdspi_pkg::PH_DUMMY: begin
						if (bc_q < sdspi_pkg::DUMMY_CNT) begin
							bc_d           = bc_q + 1'b1;
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = sdspi_pkg::IDLE_BYTE;
						end else begin
							do_start = 1'b1;
							st_idx   = sdspi_pkg::CMD_GO_IDLE;
						end
					end
					sdspi_pkg::PH_FRAME: begin
						res_d.tx_valid  = 1'b1;
						res_d.cs_active = 1'b1;
						if (bc_q < sdspi_pkg::CNT_W'(5)) begin
							bc_d          = bc_q + 1'b1;
							res_d.tx_byte = arg_byte;
						end else if (bc_q == sdspi_pkg::CNT_W'(5)) begin
							bc_d          = bc_q + 1'b1;
							res_d.tx_byte = sdspi_pkg::CMD_CRC;
						end else begin
							ph_d          = sdspi_pkg::PH_POLL;
							pc_d          = 8'd1;
							res_d.tx_byte = sdspi_pkg::IDLE_BYTE;
						end
					end
					sdspi_pkg::PH_POLL: begin
						if (rx_s1 == sdspi_pkg::IDLE_BYTE && pc_q < lim) begin
							pc_d            = pc_q + 1'b1;
							res_d.tx_valid  = 1'b1;
							res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
							res_d.cs_active = 1'b1;
						end else if (cmd_q == sdspi_pkg::CMD_GO_IDLE) begin
							do_start = 1'b1;
							st_idx   = sdspi_pkg::CMD_SEND_OP;
						end else if (cmd_q == sdspi_pkg::CMD_SEND_OP) begin
							if (rx_s1 == 8'd0) begin
								do_fin = 1'b1;
							end else begin
								do_start = 1'b1;
								st_idx   = sdspi_pkg::CMD_SEND_OP;
							end
						end else if (rx_s1 != 8'd0) begin
							do_fin = 1'b1;
							fin_st = sdspi_pkg::ST_CMD_REJ;
						end else begin
							res_d.tx_valid  = 1'b1;
							res_d.cs_active = 1'b1;
							if (cmd_q == sdspi_pkg::CMD_RD_SINGLE) begin
								ph_d          = sdspi_pkg::PH_TOKEN;
								res_d.tx_byte = sdspi_pkg::IDLE_BYTE;
							end else begin
								ph_d          = sdspi_pkg::PH_WR_TOKEN;
								res_d.tx_byte = sdspi_pkg::DATA_TOKEN;
							end
						end
					end
					sdspi_pkg::PH_TOKEN: begin
						if (rx_s1 == sdspi_pkg::DATA_TOKEN) begin
							ph_d = (len != '0) ? sdspi_pkg::PH_RD_DATA : sdspi_pkg::PH_RD_CRC;
							bc_d = sdspi_pkg::CNT_W'(1);
						end
						res_d.tx_valid  = 1'b1;
						res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
						res_d.cs_active = 1'b1;
					end
					sdspi_pkg::PH_RD_DATA: begin
						res_d.rd_valid = 1'b1;
						res_d.rd_byte  = rx_s1;
						if (bc_q < len) begin
							bc_d = bc_q + 1'b1;
						end else begin
							ph_d = sdspi_pkg::PH_RD_CRC;
							bc_d = sdspi_pkg::CNT_W'(1);
						end
						res_d.tx_valid  = 1'b1;
						res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
						res_d.cs_active = 1'b1;
					end
					sdspi_pkg::PH_RD_CRC: begin
						if (bc_q < sdspi_pkg::CNT_W'(2)) begin
							bc_d            = bc_q + 1'b1;
							res_d.tx_valid  = 1'b1;
							res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
							res_d.cs_active = 1'b1;
						end else begin
							do_fin = 1'b1;
						end
					end
					sdspi_pkg::PH_WR_TOKEN: begin
						bc_d            = sdspi_pkg::CNT_W'(1);
						res_d.tx_valid  = 1'b1;
						res_d.cs_active = 1'b1;
						if (len != '0) begin
							ph_d          = sdspi_pkg::PH_WR_DATA;
							res_d.tx_byte = wb_s1;
						end else begin
							ph_d          = sdspi_pkg::PH_WR_CRC;
							res_d.tx_byte = sdspi_pkg::IDLE_BYTE;
						end
					end
					sdspi_pkg::PH_WR_DATA: begin
						res_d.tx_valid  = 1'b1;
						res_d.cs_active = 1'b1;
						if (bc_q < len) begin
							bc_d          = bc_q + 1'b1;
							res_d.tx_byte = wb_s1;
						end else begin
							ph_d          = sdspi_pkg::PH_WR_CRC;
							bc_d          = sdspi_pkg::CNT_W'(1);
							res_d.tx_byte = sdspi_pkg::IDLE_BYTE;
						end
					end
					sdspi_pkg::PH_WR_CRC: begin
						if (bc_q < sdspi_pkg::CNT_W'(2))
							bc_d = bc_q + 1'b1;
						else
							ph_d = sdspi_pkg::PH_WR_RESP;
						res_d.tx_valid  = 1'b1;
						res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
						res_d.cs_active = 1'b1;
					end
					sdspi_pkg::PH_WR_RESP: begin
						if ((rx_s1[4:0] & sdspi_pkg::RESP_MASK) != sdspi_pkg::RESP_OK) begin
							do_fin = 1'b1;
							fin_st = sdspi_pkg::ST_DATA_REJ;
						end else begin
							ph_d            = sdspi_pkg::PH_WR_BUSY;
							res_d.tx_valid  = 1'b1;
							res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
							res_d.cs_active = 1'b1;
						end
					end
					sdspi_pkg::PH_WR_BUSY: begin
						if (rx_s1 == sdspi_pkg::BUSY_BYTE) begin
							res_d.tx_valid  = 1'b1;
							res_d.tx_byte   = sdspi_pkg::IDLE_BYTE;
							res_d.cs_active = 1'b1;
						end else begin
							do_fin = 1'b1;
						end
					end
					default: begin
						// idle: a byte item gives an empty result
						ph_d = sdspi_pkg::PH_IDLE;
					end
				endcase
			end
		endcase

		// command frame start: 0x40|cmd goes out first
		if (do_start) begin
			cmd_d           = st_idx;
			arg_d           = st_arg;
			ph_d            = sdspi_pkg::PH_FRAME;
			bc_d            = sdspi_pkg::CNT_W'(1);
			res_d.tx_valid  = 1'b1;
			res_d.tx_byte   = sdspi_pkg::CMD_START | {2'b00, st_idx};
			res_d.cs_active = 1'b1;
		end

		// operation end
		if (do_fin) begin
			ph_d            = sdspi_pkg::PH_IDLE;
			res_d.tx_valid  = 1'b0;
			res_d.tx_byte   = '0;
			res_d.cs_active = 1'b0;
			res_d.done_res  = 1'b1;
			res_d.status    = fin_st;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= sdspi_pkg::PH_IDLE;
			bc_q  <= '0;
			pc_q  <= '0;
			cmd_q <= '0;
			arg_q <= '0;
		end else if (advance) begin
			ph_q  <= ph_d;
			bc_q  <= bc_d;
			pc_q  <= pc_d;
			cmd_q <= cmd_d;
			arg_q <= arg_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = {res_q.rd_valid, res_q.tx_valid};
	assign m_axis_tdata  = {4'b0000, res_q.status, res_q.done_res, res_q.rd_byte,
	                        res_q.cs_active, res_q.tx_byte};

endmodule
`default_nettype wire
